// File: hdl/gtd_pkg.sv
// ----------------------------------------------------------------------------
// gtd_pkg
// shared types and codes for the track delta decoder
// ----------------------------------------------------------------------------
package gtd_pkg;

  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_TOTAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PTS   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LON   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LAT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ALT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERR   = 3'd5;

  localparam logic [1:0] PH_TOTAL = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_FIRST = 2'd2;
  localparam logic [1:0] PH_DELTA = 2'd3;

  localparam logic [1:0] AXIS_ALT = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [31:0]       value;
    logic [KIND_W-1:0] kind;
    logic              stream_done;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hdl/gtd_byte_if.sv
// ----------------------------------------------------------------------------
// gtd_byte_if
// byte stream channel: valid, ready and one stream byte
// ----------------------------------------------------------------------------
interface gtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       final_byte;

  modport source (output valid, output byte_req, output final_byte, input ready);
  modport sink (input valid, input byte_req, input final_byte, output ready);
endinterface

// File: hdl/gtd_word_if.sv
// ----------------------------------------------------------------------------
// gtd_word_if
// decoded word channel: valid, ready and one result
// ----------------------------------------------------------------------------
interface gtd_word_if
  import gtd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [31:0]       value;
  logic [KIND_W-1:0] kind;
  logic              stream_done;
  logic              last_of_run;

  modport source (output valid, output value, output kind, output stream_done,
                  output last_of_run, input ready);
  modport sink (input valid, input value, input kind, input stream_done,
                input last_of_run, output ready);
endinterface

// File: hdl/gtd_decode.sv
// ----------------------------------------------------------------------------
// gtd_decode
// input register, stream state and per-byte word / varint delta decoding
// ----------------------------------------------------------------------------
module gtd_decode
  import gtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gtd_byte_if.sink    stream,
  input  logic        room,
  output push_t       push
);

  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic        stg_final;
  logic        fire;

  logic [1:0]  phase, phase_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [31:0] word_buffer, word_buffer_next;
  logic [31:0] segments_left, segments_left_next;
  logic [31:0] points_left, points_left_next;
  logic [31:0] prev [3];
  logic [31:0] prev_next [3];
  logic [31:0] delta_magnitude, delta_magnitude_next;
  logic        delta_negative, delta_negative_next;
  logic [2:0]  delta_byte_count, delta_byte_count_next;
  logic [1:0]  axis, axis_next;
  logic        finished, finished_next;

  logic [1:0]        ax;
  logic [31:0]       word;
  logic [31:0]       delta;
  logic [31:0]       coord;
  logic              adv;
  logic              seg_end;
  logic              r_valid;
  logic [31:0]       r_value;
  logic [KIND_W-1:0] r_kind;
  logic              r_done;
  logic              trunc;

  assign fire         = stg_valid && room;
  assign stream.ready = !stg_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      stg_valid <= 1'b1;
    end else if (fire) begin
      stg_valid <= 1'b0;
    end
    if (stream.valid && stream.ready) begin
      stg_byte  <= stream.byte_req;
      stg_final <= stream.final_byte;
    end
  end

  assign ax   = (axis > AXIS_ALT) ? AXIS_ALT : axis;
  assign word = {stg_byte, word_buffer[23:0]};

  always_comb begin
    phase_next            = phase;
    byte_in_word_next     = byte_in_word;
    word_buffer_next      = word_buffer;
    segments_left_next    = segments_left;
    points_left_next      = points_left;
    prev_next             = prev;
    delta_magnitude_next  = delta_magnitude;
    delta_negative_next   = delta_negative;
    delta_byte_count_next = delta_byte_count;
    axis_next             = axis;
    finished_next         = finished;
    delta                 = '0;
    coord                 = '0;
    adv                   = 1'b0;
    seg_end               = 1'b0;
    r_valid               = 1'b0;
    r_value               = word;
    r_kind                = KIND_TOTAL;
    r_done                = 1'b0;
    trunc                 = 1'b0;

    if (fire && !finished) begin
      if (phase == PH_DELTA) begin
        unique case (delta_byte_count)
          3'd0: begin
            delta_negative_next  = stg_byte[6];
            delta_magnitude_next = {26'b0, stg_byte[5:0]};
          end
          3'd1: delta_magnitude_next = delta_magnitude | ({25'b0, stg_byte[6:0]} << 6);
          3'd2: delta_magnitude_next = delta_magnitude | ({25'b0, stg_byte[6:0]} << 13);
          3'd3: delta_magnitude_next = delta_magnitude | ({25'b0, stg_byte[6:0]} << 20);
          3'd4: delta_magnitude_next = delta_magnitude | ({25'b0, stg_byte[6:0]} << 27);
          default: delta_magnitude_next = delta_magnitude;
        endcase
        delta_byte_count_next = delta_byte_count + 3'd1;
        if (!stg_byte[7] || delta_byte_count >= 3'd5) begin
          delta = delta_negative_next ? (32'd0 - delta_magnitude_next)
                                      : delta_magnitude_next;
          coord = prev[ax] + delta;
          prev_next[ax]         = coord;
          r_valid               = 1'b1;
          r_value               = coord;
          r_kind                = KIND_LON + {1'b0, ax};
          delta_magnitude_next  = '0;
          delta_negative_next   = 1'b0;
          delta_byte_count_next = '0;
          adv                   = 1'b1;
        end
      end else begin
        if (byte_in_word == 2'd0) begin
          word_buffer_next = {24'b0, stg_byte};
        end else begin
          word_buffer_next = word_buffer | ({24'b0, stg_byte} << {byte_in_word, 3'b000});
        end
        if (byte_in_word == 2'd3) begin
          byte_in_word_next = '0;
          r_valid           = 1'b1;
          unique case (phase)
            PH_COUNT: begin
              r_kind = KIND_PTS;
              if (word == 32'd0) begin
                seg_end = 1'b1;
              end else begin
                points_left_next = word - 32'd1;
                axis_next        = '0;
                phase_next       = PH_FIRST;
              end
            end
            PH_FIRST: begin
              prev_next[ax] = word;
              r_kind        = KIND_LON + {1'b0, ax};
              adv           = 1'b1;
            end
            default: begin
              segments_left_next = word;
              r_kind             = KIND_TOTAL;
              if (word == 32'd0) begin
                finished_next = 1'b1;
              end else begin
                phase_next = PH_COUNT;
              end
            end
          endcase
        end else begin
          byte_in_word_next = byte_in_word + 2'd1;
        end
      end

      if (adv) begin
        if (ax == AXIS_ALT) begin
          axis_next = '0;
          if (phase == PH_FIRST) begin
            if (points_left == 32'd0) begin
              seg_end = 1'b1;
            end else begin
              phase_next = PH_DELTA;
            end
          end else begin
            points_left_next = points_left - 32'd1;
            if (points_left_next == 32'd0) begin
              seg_end = 1'b1;
            end
          end
        end else begin
          axis_next = ax + 2'd1;
        end
      end

      if (seg_end) begin
        segments_left_next = segments_left - 32'd1;
        if (segments_left_next == 32'd0) begin
          finished_next = 1'b1;
        end else begin
          phase_next = PH_COUNT;
        end
      end

      r_done = finished_next;
      trunc  = stg_final && !finished_next;
      if (trunc) begin
        finished_next = 1'b1;
      end
    end
  end

  always_comb begin
    push.n              = {1'b0, r_valid} + {1'b0, trunc};
    push.r1.value       = '0;
    push.r1.kind        = KIND_ERR;
    push.r1.stream_done = 1'b0;
    push.r1.last_of_run = 1'b1;
    if (r_valid) begin
      push.r0.value       = r_value;
      push.r0.kind        = r_kind;
      push.r0.stream_done = r_done;
      push.r0.last_of_run = !trunc;
    end else begin
      push.r0 = push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TOTAL;
      byte_in_word     <= '0;
      word_buffer      <= '0;
      segments_left    <= '0;
      points_left      <= '0;
      prev[0]          <= '0;
      prev[1]          <= '0;
      prev[2]          <= '0;
      delta_magnitude  <= '0;
      delta_negative   <= 1'b0;
      delta_byte_count <= '0;
      axis             <= '0;
      finished         <= 1'b0;
    end else begin
      phase            <= phase_next;
      byte_in_word     <= byte_in_word_next;
      word_buffer      <= word_buffer_next;
      segments_left    <= segments_left_next;
      points_left      <= points_left_next;
      prev             <= prev_next;
      delta_magnitude  <= delta_magnitude_next;
      delta_negative   <= delta_negative_next;
      delta_byte_count <= delta_byte_count_next;
      axis             <= axis_next;
      finished         <= finished_next;
    end
  end

endmodule

// File: hdl/gtd_fifo.sv
// ----------------------------------------------------------------------------
// gtd_fifo
// result queue: takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
module gtd_fifo
  import gtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic        room,
  gtd_word_if.source  words
);

  result_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               pop;
  result_t            head;

  assign room = count <= CNT_W'(FIFO_DEPTH - 2);
  assign pop  = words.valid && words.ready;
  assign head = slots[rd_ptr];

  assign words.valid       = count != '0;
  assign words.value       = head.value;
  assign words.kind        = head.kind;
  assign words.stream_done = head.stream_done;
  assign words.last_of_run = head.last_of_run;

  assign count_next = count + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slots[PTR_W'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + push.n);
      rd_ptr <= PTR_W'(rd_ptr + pop);
      count  <= count_next;
    end
  end

endmodule

// File: hdl/gps_track_delta_decoder.sv
// ----------------------------------------------------------------------------
// gps_track_delta_decoder
// decodes a delta-compressed track byte stream into 32-bit words
// ----------------------------------------------------------------------------
// path: input register, decode logic, then the result queue to the output
// throughput: one byte per cycle while the queue has room; a byte may give two results
// the input register waits only when the four-entry result queue is nearly full
// reset: synchronous, clears stream state, the input register and the queue
module gps_track_delta_decoder
  import gtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  gtd_byte_if.sink    stream,
  gtd_word_if.source  words
);

  push_t push;
  logic  room;

  gtd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .room   (room),
    .push   (push)
  );

  gtd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .words (words)
  );

endmodule

// File: hdl/gtd_checker.sv
// ----------------------------------------------------------------------------
// gtd_checker
// port-level checks on the decoded word channel
// ----------------------------------------------------------------------------
module gtd_checker
  import gtd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              words_valid,
  input logic              words_ready,
  input logic [31:0]       words_value,
  input logic [KIND_W-1:0] words_kind,
  input logic              words_stream_done,
  input logic              words_last_of_run
);

  logic done_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_seen <= 1'b0;
    end else if (words_valid && words_ready &&
                 (words_stream_done || words_kind == KIND_ERR)) begin
      done_seen <= 1'b1;
    end
  end

  // nothing follows the end of the stream
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    done_seen |-> !words_valid)
    else $error("result after end of stream");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    words_valid && words_kind == KIND_ERR |->
      words_value == 32'd0 && !words_stream_done && words_last_of_run)
    else $error("malformed truncation result");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    words_valid && words_stream_done |-> words_last_of_run)
    else $error("stream end not last of run");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    words_valid |-> words_kind <= KIND_ERR)
    else $error("unknown result kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    words_valid && !words_ready |=>
      words_valid && $stable(words_value) && $stable(words_kind))
    else $error("stalled result changed");

endmodule

bind gps_track_delta_decoder gtd_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .words_valid       (words.valid),
  .words_ready       (words.ready),
  .words_value       (words.value),
  .words_kind        (words.kind),
  .words_stream_done (words.stream_done),
  .words_last_of_run (words.last_of_run)
);

// File: tb/sv/gps_track_delta_decoder_tb.sv
// ----------------------------------------------------------------------------
// gps_track_delta_decoder_tb
// Sends one long compressed track through the decoder. The track opens with a
// short directed part: the segment total, an empty segment, and a segment with
// extreme first-point words and long, negative and high-bit deltas. Random
// segments with random deltas follow. The track either runs to its last
// segment or is cut short by an early final byte, and a few ignored bytes come
// after the end. Every decoded word is checked field by field against an
// in-bench decoder model, while the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module gps_track_delta_decoder_tb;
  import gtd_pkg::*;

  localparam int DIR_ROWS    = 32;
  localparam int RAND_SEGS   = 24;  // directed part uses two of the 26 segments
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0]        b;
    logic              fin;
    logic              known;
    logic [31:0]       value;
    logic [KIND_W-1:0] kind;
  } stim_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst;

  gtd_byte_if stream_if ();
  gtd_word_if word_if ();

  gps_track_delta_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .words  (word_if)
  );

  idle_mode_e idle_mode = IDLE_NONE;
  stim_row_t  cur_row;
  result_t    pending_words [$];
  result_t    step_words [2];
  int         step_n;
  int         fail_count = 0;
  int         words_checked = 0;
  int         bytes_taken = 0;
  int         ignored_bytes = 0;
  int         pair_count = 0;
  int         cycle_count;

  // decoder model state
  logic [1:0]  trk_phase;
  logic [1:0]  trk_pos;
  logic [31:0] trk_word;
  logic [31:0] trk_segs;
  logic [31:0] trk_pts;
  logic [31:0] trk_coord [3];
  logic [31:0] trk_mag;
  logic        trk_neg;
  logic [2:0]  trk_nbytes;
  logic [1:0]  trk_axis;
  logic        trk_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t plain_row(input logic [7:0] b);
    plain_row = '0;
    plain_row.b = b;
  endfunction

  function automatic stim_row_t known_row(input logic [7:0] b, input logic [31:0] v,
                                          input logic [KIND_W-1:0] k);
    known_row = '0;
    known_row.b = b;
    known_row.known = 1'b1;
    known_row.value = v;
    known_row.kind = k;
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 76;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 76;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  task automatic emit_word(input logic [31:0] v, input logic [KIND_W-1:0] k);
    step_words[step_n] = {v, k, 1'b0, 1'b0};
    step_n++;
  endtask

  task automatic close_segment();
    trk_segs = trk_segs - 1;
    if (trk_segs == 0) begin
      trk_done = 1'b1;
    end else begin
      trk_phase = PH_COUNT;
    end
  endtask

  task automatic step_axis();
    if (trk_axis == AXIS_ALT) begin
      trk_axis = '0;
      if (trk_phase == PH_FIRST) begin
        if (trk_pts == 0) begin
          close_segment();
        end else begin
          trk_phase = PH_DELTA;
        end
      end else begin
        trk_pts = trk_pts - 1;
        if (trk_pts == 0) begin
          close_segment();
        end
      end
    end else begin
      trk_axis = trk_axis + 2'd1;
    end
  endtask

  // expected words for one accepted byte, left in step_words
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [31:0] w;
    logic [31:0] d;
    step_n = 0;
    if (trk_done) return;
    if (trk_phase == PH_DELTA) begin
      if (trk_nbytes == 0) begin
        trk_neg = b[6];
        trk_mag = {26'd0, b[5:0]};
      end else if (trk_nbytes <= 4) begin
        trk_mag = trk_mag | ({25'd0, b[6:0]} << (6 + 7 * (trk_nbytes - 1)));
      end
      trk_nbytes = trk_nbytes + 3'd1;
      if (!b[7] || trk_nbytes >= 6) begin
        d = trk_neg ? (32'd0 - trk_mag) : trk_mag;
        w = trk_coord[trk_axis] + d;
        trk_coord[trk_axis] = w;
        emit_word(w, KIND_LON + {1'b0, trk_axis});
        trk_mag = '0;
        trk_neg = 1'b0;
        trk_nbytes = '0;
        step_axis();
      end
    end else begin
      if (trk_pos == 0) begin
        trk_word = {24'd0, b};
      end else begin
        trk_word = trk_word | ({24'd0, b} << (8 * trk_pos));
      end
      if (trk_pos == 3) begin
        trk_pos = '0;
        w = trk_word;
        if (trk_phase == PH_COUNT) begin
          emit_word(w, KIND_PTS);
          if (w == 0) begin
            close_segment();
          end else begin
            trk_pts = w - 1;
            trk_axis = '0;
            trk_phase = PH_FIRST;
          end
        end else if (trk_phase == PH_FIRST) begin
          trk_coord[trk_axis] = w;
          emit_word(w, KIND_LON + {1'b0, trk_axis});
          step_axis();
        end else begin
          trk_segs = w;
          emit_word(w, KIND_TOTAL);
          if (w == 0) begin
            trk_done = 1'b1;
          end else begin
            trk_phase = PH_COUNT;
          end
        end
      end else begin
        trk_pos = trk_pos + 2'd1;
      end
    end
    if (trk_done && step_n > 0) begin
      step_words[step_n-1].stream_done = 1'b1;
    end
    if (fin && !trk_done) begin
      emit_word(32'd0, KIND_ERR);
      trk_done = 1'b1;
    end
    if (step_n > 0) begin
      step_words[step_n-1].last_of_run = 1'b1;
    end
  endtask

  task automatic send_row(input stim_row_t r);
    while (sender_waits()) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid      <= 1'b1;
    stream_if.byte_req   <= r.b;
    stream_if.final_byte <= r.fin;
    cur_row              <= r;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
  endtask

  // receiver
  initial begin
    word_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      word_if.ready <= !receiver_stalls();
    end
  end

  // predict on each byte transaction, check each word transaction
  always @(posedge clk) begin : track_words
    result_t got;
    result_t want;
    if (rst) begin
      trk_phase  = PH_TOTAL;
      trk_pos    = '0;
      trk_word   = '0;
      trk_segs   = '0;
      trk_pts    = '0;
      trk_coord  = '{default: '0};
      trk_mag    = '0;
      trk_neg    = 1'b0;
      trk_nbytes = '0;
      trk_axis   = '0;
      trk_done   = 1'b0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        if (trk_done) ignored_bytes++;
        decode_byte(stream_if.byte_req, stream_if.final_byte);
        if (cur_row.known && step_n > 0) begin
          step_words[0].value = cur_row.value;
          step_words[0].kind  = cur_row.kind;
        end
        for (int k = 0; k < step_n; k++) pending_words.push_back(step_words[k]);
        if (step_n == 2) pair_count++;
        bytes_taken++;
      end
      if (word_if.valid && word_if.ready) begin
        got = {word_if.value, word_if.kind, word_if.stream_done, word_if.last_of_run};
        words_checked++;
        if (pending_words.size() == 0) begin
          note_failure($sformatf("unexpected word value %h kind %0d done %0b last %0b",
                                 got.value, got.kind, got.stream_done, got.last_of_run));
        end else begin
          want = pending_words.pop_front();
          if (got.value !== want.value || got.kind !== want.kind ||
              got.stream_done !== want.stream_done || got.last_of_run !== want.last_of_run) begin
            note_failure($sformatf({"word mismatch: expected value %h kind %0d done %0b ",
                                    "last %0b, got value %h kind %0d done %0b last %0b"},
                                   want.value, want.kind, want.stream_done, want.last_of_run,
                                   got.value, got.kind, got.stream_done, got.last_of_run));
          end
        end
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles, %0d words still expected",
             cycle_count, pending_words.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic gen_word(ref stim_row_t rows [$], input logic [31:0] w);
    for (int k = 0; k < 4; k++) rows.push_back(plain_row(w[8*k +: 8]));
  endtask

  initial begin : stimulus
    stim_row_t   directed_rows [DIR_ROWS];
    stim_row_t   rand_rows [$];
    stim_row_t   row;
    int          cnt;
    int          pick;
    int          dlen;
    int          cut;
    int          drain;
    bit          truncate;
    logic [31:0] w;
    logic [7:0]  b;
    result_t     left;

    rst                  <= 1'b1;
    stream_if.valid      <= 1'b0;
    stream_if.byte_req   <= '0;
    stream_if.final_byte <= 1'b0;
    cur_row              <= '0;

    directed_rows = '{
      plain_row(8'h1A), plain_row(8'h00), plain_row(8'h00),
      known_row(8'h00, 32'h0000_001A, KIND_TOTAL),
      // empty segment
      plain_row(8'h00), plain_row(8'h00), plain_row(8'h00),
      known_row(8'h00, 32'h0000_0000, KIND_PTS),
      plain_row(8'h02), plain_row(8'h00), plain_row(8'h00),
      known_row(8'h00, 32'h0000_0002, KIND_PTS),
      plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
      known_row(8'hFF, 32'hFFFF_FFFF, KIND_LON),
      plain_row(8'h00), plain_row(8'h00), plain_row(8'h00),
      known_row(8'h80, 32'h8000_0000, KIND_LAT),
      plain_row(8'h00), plain_row(8'h00), plain_row(8'h00),
      known_row(8'h00, 32'h0000_0000, KIND_ALT),
      // six-byte delta, all data bits set, top bits dropped
      plain_row(8'hBF), plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
      plain_row(8'hFF),
      known_row(8'hFF, 32'hFFFF_FFFE, KIND_LON),
      known_row(8'h41, 32'h7FFF_FFFF, KIND_LAT),
      known_row(8'h3F, 32'h0000_003F, KIND_ALT)
    };

    repeat (RAND_SEGS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        cnt = 0;
      end else if (pick < 20) begin
        cnt = 1;
      end else if (pick < 92) begin
        cnt = $urandom_range(10, 2);
      end else begin
        cnt = $urandom_range(40, 11);
      end
      gen_word(rand_rows, cnt);
      if (cnt != 0) begin
        repeat (3) begin
          case ($urandom_range(7))
            0: w = 32'hFFFF_FFFF;
            1: w = 32'h0000_0000;
            2: w = 32'h8000_0000;
            default: w = $urandom();
          endcase
          gen_word(rand_rows, w);
        end
        repeat ((cnt - 1) * 3) begin
          pick = $urandom_range(99);
          dlen = (pick < 35) ? 1 : (pick < 60) ? 2 : (pick < 75) ? 3 :
                 (pick < 85) ? 4 : (pick < 93) ? 5 : 6;
          for (int k = 1; k <= dlen; k++) begin
            b = 8'($urandom_range(255));
            if (k < dlen) begin
              b[7] = 1'b1;
            end else if (dlen < 6) begin
              b[7] = 1'b0;
            end
            rand_rows.push_back(plain_row(b));
          end
        end
      end
    end

    // end the track early or on its last byte, then bytes that are ignored
    truncate = 1'($urandom_range(1));
    cut = truncate ? $urandom_range(rand_rows.size() - 2, rand_rows.size() - 60)
                   : rand_rows.size() - 1;
    row = rand_rows[cut];
    row.fin = 1'b1;
    rand_rows[cut] = row;
    repeat (8) begin
      row = plain_row(8'($urandom_range(255)));
      row.fin = 1'($urandom_range(1));
      rand_rows.push_back(row);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    foreach (rand_rows[i]) begin
      idle_mode <= idle_mode_e'((i * 8 / rand_rows.size()) % 4);
      send_row(rand_rows[i]);
    end
    stream_if.valid <= 1'b0;

    drain = 0;
    while (pending_words.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_words.size() != 0) begin
      left = pending_words.pop_front();
      note_failure($sformatf("missing word value %h kind %0d done %0b last %0b",
                             left.value, left.kind, left.stream_done, left.last_of_run));
    end

    $display("%0d bytes sent (%0d after the end), %0d words checked, %0d bytes gave two words",
             bytes_taken, ignored_bytes, words_checked, pair_count);
    $display("track %s, %0d mismatches", truncate ? "cut short by an early final byte"
                                                  : "run to its last segment", fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
